// File: rtl/pdmrms_pkg.sv
// Shared types, constants and helper functions of the PDM level meter.
// Used by the top level, the front part and the back part; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pdmrms_pkg;

  localparam int MOVING_AVG_TAPS_DEF = 8;

  // Fixed field widths.
  localparam int PDM_W     = 16;
  localparam int VAL_W     = 6;
  localparam int DECIM_W   = 7;
  localparam int WIN_W     = 12;
  localparam int RMSLIM_W  = 16;
  localparam int PEAKLIM_W = 11;
  localparam int MS_W      = 25;
  localparam int RMS_W     = 13;
  localparam int PEAK_W    = 8;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [DECIM_W-1:0]   DECIM_MAX     = 7'd64;
  localparam logic [DECIM_W-1:0]   DECIM_RST     = 7'd8;
  localparam logic [WIN_W-1:0]     WIN_RST       = 12'd313;
  localparam logic [RMSLIM_W-1:0]  RMSLIM_RST    = 16'd64225;
  localparam logic [PEAKLIM_W-1:0] PEAKLIM_RST   = 11'd2007;
  localparam logic [MS_W-1:0]      MS_MAX        = 25'h1FFFFFF;
  localparam logic [PEAK_W-1:0]    PEAK_OUT_MAX  = 8'd255;

  // Square root: one result bit per step, 13 steps over a 25-bit operand.
  localparam int                SQRT_STEPS = 13;
  localparam logic [MS_W-1:0]   SQRT_BIT0  = 25'h1000000;

  localparam int JOB_QUEUE_DEPTH = 4;
  localparam int RES_QUEUE_DEPTH = 2;
  // Words still in the front pipeline can each close a window.
  localparam int JOB_FULL_MARK   = JOB_QUEUE_DEPTH - 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIM_FACTOR   = 2'd0,
    REG_WINDOW_LEN     = 2'd1,
    REG_SAT_RMS_LIMIT  = 2'd2,
    REG_SAT_PEAK_LIMIT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DECIM_W-1:0]   decim_factor;
    logic [WIN_W-1:0]     window_len;
    logic [RMSLIM_W-1:0]  sat_rms_limit;
    logic [PEAKLIM_W-1:0] sat_peak_limit;
  } cfg_t;

  typedef struct packed {
    logic             status;
    logic [MS_W-1:0]  mean_square;
    logic [RMS_W-1:0] rms_level;
    logic [PEAK_W-1:0] peak_level;
  } result_t;

  // Maps a PDM word to 2*ones - 16, a value in [-16, 16].
  function automatic logic signed [VAL_W-1:0] pdm_value(input logic [PDM_W-1:0] word);
    logic [4:0] ones;
    logic [6:0] tmp;
    ones = '0;
    for (int i = 0; i < PDM_W; i++) begin
      ones = ones + 5'(word[i]);
    end
    tmp = {1'b0, ones, 1'b0} - 7'd16;
    return tmp[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/pdm_decimator_rms_meter.sv
// PDM level meter, top level: configuration registers, front part, job queue,
// back part and result queue. Depends on pdmrms_pkg and all pdmrms_* modules.
// Throughput: one PDM word per cycle; push is refused only while two or more window jobs wait.
// A window-closing word passes the stage B and C registers of the front part into the job
// queue; the shared divider/root unit then evaluates one window at a time.
// Reset: asynchronous, clears history, counters, queues and loads default registers.
`timescale 1ns / 1ps
`default_nettype none

module pdm_decimator_rms_meter #(
  parameter int MOVING_AVG_TAPS = pdmrms_pkg::MOVING_AVG_TAPS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [pdmrms_pkg::PDM_W-1:0]         pdm_word_i,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic                                      status_o,
  output logic [pdmrms_pkg::MS_W-1:0]               mean_square_o,
  output logic [pdmrms_pkg::RMS_W-1:0]              rms_level_o,
  output logic [pdmrms_pkg::PEAK_W-1:0]             peak_level_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [pdmrms_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pdmrms_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int MAGW  = $clog2(16 * MOVING_AVG_TAPS + 1);
  localparam int SQW   = 2 * MAGW + pdmrms_pkg::WIN_W;
  localparam int JOBW  = SQW + pdmrms_pkg::WIN_W + MAGW;
  localparam int RESW  = $bits(pdmrms_pkg::result_t);
  localparam int JQD   = pdmrms_pkg::JOB_QUEUE_DEPTH;
  localparam int JQCW  = $clog2(JQD + 1);
  localparam int RQD   = pdmrms_pkg::RES_QUEUE_DEPTH;
  localparam int RQCW  = $clog2(RQD + 1);

  pdmrms_pkg::cfg_t    cfg_q;
  pdmrms_pkg::result_t res_push_data;
  pdmrms_pkg::result_t res_head;

  logic                          accept;
  logic                          job_push;
  logic [SQW-1:0]                job_sum_sq;
  logic [pdmrms_pkg::WIN_W-1:0]  job_count;
  logic [MAGW-1:0]               job_peak;
  logic [JOBW-1:0]               job_head;
  logic                          job_full;
  logic                          job_empty;
  logic                          job_pop;
  logic [JQCW-1:0]               job_count_q;
  logic                          res_push;
  logic                          res_full;
  logic                          res_pop;
  logic [RESW-1:0]               res_head_bits;
  logic [RQCW-1:0]               res_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decim_factor   <= pdmrms_pkg::DECIM_RST;
      cfg_q.window_len     <= pdmrms_pkg::WIN_RST;
      cfg_q.sat_rms_limit  <= pdmrms_pkg::RMSLIM_RST;
      cfg_q.sat_peak_limit <= pdmrms_pkg::PEAKLIM_RST;
    end else if (cfg_valid_i) begin
      unique case (pdmrms_pkg::reg_idx_e'(cfg_index_i))
        pdmrms_pkg::REG_DECIM_FACTOR: begin
          cfg_q.decim_factor <= cfg_data_i[pdmrms_pkg::DECIM_W-1:0];
        end
        pdmrms_pkg::REG_WINDOW_LEN: begin
          cfg_q.window_len <= cfg_data_i[pdmrms_pkg::WIN_W-1:0];
        end
        pdmrms_pkg::REG_SAT_RMS_LIMIT: begin
          cfg_q.sat_rms_limit <= cfg_data_i[pdmrms_pkg::RMSLIM_W-1:0];
        end
        pdmrms_pkg::REG_SAT_PEAK_LIMIT: begin
          cfg_q.sat_peak_limit <= cfg_data_i[pdmrms_pkg::PEAKLIM_W-1:0];
        end
      endcase
    end
  end

  // Leave room in the job queue for the words still in the front pipeline.
  assign full   = (job_count_q >= JQCW'(pdmrms_pkg::JOB_FULL_MARK));
  assign accept = push && !full;

  pdmrms_front #(
    .TAPS (MOVING_AVG_TAPS),
    .MAGW (MAGW),
    .SQW  (SQW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pdm_word_i   (pdm_word_i),
    .cfg_i        (cfg_q),
    .job_push_o   (job_push),
    .job_sum_sq_o (job_sum_sq),
    .job_count_o  (job_count),
    .job_peak_o   (job_peak)
  );

  pdmrms_queue #(
    .WIDTH (JOBW),
    .DEPTH (JQD)
  ) u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  ({job_sum_sq, job_count, job_peak}),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .empty_o (job_empty),
    .count_o (job_count_q)
  );

  pdmrms_back #(
    .TAPS (MOVING_AVG_TAPS),
    .MAGW (MAGW),
    .SQW  (SQW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .job_valid_i  (!job_empty),
    .job_sum_sq_i (job_head[JOBW-1 -: SQW]),
    .job_count_i  (job_head[MAGW +: pdmrms_pkg::WIN_W]),
    .job_peak_i   (job_head[MAGW-1:0]),
    .job_pop_o    (job_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_push_data)
  );

  assign res_pop = pop && !empty;

  pdmrms_queue #(
    .WIDTH (RESW),
    .DEPTH (RQD)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_push_data),
    .full_o  (res_full),
    .pop_i   (res_pop),
    .data_o  (res_head_bits),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign res_head      = pdmrms_pkg::result_t'(res_head_bits);
  assign status_o      = res_head.status;
  assign mean_square_o = res_head.mean_square;
  assign rms_level_o   = res_head.rms_level;
  assign peak_level_o  = res_head.peak_level;

  a_job_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_full |-> !accept)
    else $error("word accepted with no room for its window job");

  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty == (res_count == '0))
    else $error("result queue empty flag disagrees with its count");

  a_one_result_per_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> !res_push)
    else $error("two results pushed back to back by one evaluation unit");

endmodule

`default_nettype wire

// File: rtl/pdmrms_queue.sv
// Small register queue with push/full and pop/empty sides.
// Depends on nothing; used for the job queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module pdmrms_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           data_i,
  output logic                            full_o,
  input  wire logic                       pop_i,
  output logic [WIDTH-1:0]                data_o,
  output logic                            empty_o,
  output logic [$clog2(DEPTH+1)-1:0]      count_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue pushed while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: rtl/pdmrms_front.sv
// Front part: PDM word to value, moving-average history, decimation and
// per-window square sum and peak. Depends on pdmrms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdmrms_front #(
  parameter int TAPS = pdmrms_pkg::MOVING_AVG_TAPS_DEF,
  parameter int MAGW = 8,
  parameter int SQW  = 28
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire logic [pdmrms_pkg::PDM_W-1:0]        pdm_word_i,
  input  wire pdmrms_pkg::cfg_t                    cfg_i,
  output logic                                     job_push_o,
  output logic [SQW-1:0]                           job_sum_sq_o,
  output logic [pdmrms_pkg::WIN_W-1:0]             job_count_o,
  output logic [MAGW-1:0]                          job_peak_o
);

  localparam int VW    = pdmrms_pkg::VAL_W;
  localparam int SUMW  = MAGW + 1;
  localparam int PHW   = pdmrms_pkg::DECIM_W - 1;
  localparam int DW    = pdmrms_pkg::DECIM_W;
  localparam int WW    = pdmrms_pkg::WIN_W;

  // Stage A: history and running tap sum.
  logic signed [VW-1:0]   taps_q [TAPS];
  logic signed [SUMW-1:0] tap_sum_q, tap_sum_d;
  logic [PHW-1:0]         phase_q;
  logic signed [VW-1:0]   value;
  logic [DW-1:0]          decim;
  logic [DW-1:0]          phase_inc;
  logic                   take;

  // Stage B: magnitude and square.
  logic                   s1_valid_q;
  logic signed [SUMW-1:0] s1_acc_q;
  logic [MAGW-1:0]        mag;

  // Stage C: window accumulation.
  logic                   s2_valid_q;
  logic [MAGW-1:0]        s2_mag_q;
  logic [2*MAGW-1:0]      s2_sq_q;
  logic [SQW-1:0]         win_sum_q, win_sum_d;
  logic [MAGW-1:0]        win_peak_q, win_peak_d;
  logic [WW-1:0]          win_count_q, win_count_d;
  logic [WW-1:0]          win_len;
  logic                   win_end;

  always_comb begin
    value = pdmrms_pkg::pdm_value(pdm_word_i);
    // The running sum stays equal to the sum over the whole history.
    tap_sum_d = tap_sum_q + SUMW'(value) - SUMW'(taps_q[TAPS-1]);
    if (cfg_i.decim_factor == '0) begin
      decim = DW'(1);
    end else if (cfg_i.decim_factor > pdmrms_pkg::DECIM_MAX) begin
      decim = pdmrms_pkg::DECIM_MAX;
    end else begin
      decim = cfg_i.decim_factor;
    end
    take      = (phase_q == '0);
    phase_inc = DW'(phase_q) + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        taps_q[i] <= '0;
      end
      tap_sum_q  <= '0;
      phase_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i && take;
      if (accept_i) begin
        taps_q[0] <= value;
        for (int i = 1; i < TAPS; i++) begin
          taps_q[i] <= taps_q[i-1];
        end
        tap_sum_q <= tap_sum_d;
        phase_q   <= (phase_inc >= decim) ? '0 : phase_inc[PHW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_acc_q <= tap_sum_d;
    end
  end

  assign mag = (s1_acc_q < 0) ? MAGW'(-s1_acc_q) : MAGW'(s1_acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_mag_q <= mag;
      s2_sq_q  <= (2*MAGW)'(mag) * (2*MAGW)'(mag);
    end
  end

  always_comb begin
    win_len     = (cfg_i.window_len == '0) ? WW'(1) : cfg_i.window_len;
    win_sum_d   = win_sum_q + SQW'(s2_sq_q);
    win_peak_d  = (s2_mag_q > win_peak_q) ? s2_mag_q : win_peak_q;
    win_count_d = win_count_q + 1'b1;
    win_end     = (win_count_d >= win_len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_sum_q   <= '0;
      win_peak_q  <= '0;
      win_count_q <= '0;
    end else if (s2_valid_q) begin
      if (win_end) begin
        win_sum_q   <= '0;
        win_peak_q  <= '0;
        win_count_q <= '0;
      end else begin
        win_sum_q   <= win_sum_d;
        win_peak_q  <= win_peak_d;
        win_count_q <= win_count_d;
      end
    end
  end

  assign job_push_o   = s2_valid_q && win_end;
  assign job_sum_sq_o = win_sum_d;
  assign job_count_o  = win_count_d;
  assign job_peak_o   = win_peak_d;

endmodule

`default_nettype wire

// File: rtl/pdmrms_back.sv
// Back part: per-window mean square by restoring division, bit-serial
// square root and saturation check. Depends on pdmrms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdmrms_back #(
  parameter int TAPS = pdmrms_pkg::MOVING_AVG_TAPS_DEF,
  parameter int MAGW = 8,
  parameter int SQW  = 28
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pdmrms_pkg::cfg_t              cfg_i,
  input  wire logic                          job_valid_i,
  input  wire logic [SQW-1:0]                job_sum_sq_i,
  input  wire logic [pdmrms_pkg::WIN_W-1:0]  job_count_i,
  input  wire logic [MAGW-1:0]               job_peak_i,
  output logic                               job_pop_o,
  input  wire logic                          res_full_i,
  output logic                               res_push_o,
  output pdmrms_pkg::result_t                res_o
);

  localparam int FW    = pdmrms_pkg::FRAC_W;
  localparam int NUMW  = SQW + FW;
  localparam int CNTW  = pdmrms_pkg::WIN_W;
  localparam int TT    = TAPS * TAPS;
  localparam int TTW   = $clog2(TT + 1);
  localparam int DENW  = CNTW + TTW;
  localparam int DIVCW = $clog2(NUMW);
  localparam int MSW   = pdmrms_pkg::MS_W;
  localparam int RMSW  = pdmrms_pkg::RMS_W;
  localparam int PKCW  = (MAGW > pdmrms_pkg::PEAKLIM_W) ? MAGW : pdmrms_pkg::PEAKLIM_W;
  localparam int SQCW  = $clog2(pdmrms_pkg::SQRT_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [NUMW-1:0]   num_q;      // dividend, then quotient
  logic [CNTW-1:0]   cnt_q;
  logic [MAGW-1:0]   peak_q;
  logic [DENW-1:0]   den_q;
  logic [DENW-1:0]   rem_q;
  logic [DIVCW-1:0]  step_q;
  logic [MSW-1:0]    ms_q;
  logic [MSW-1:0]    x_q;
  logic [MSW:0]      r_q;
  logic [MSW-1:0]    bit_q;
  logic [SQCW-1:0]   sq_step_q;

  logic [DENW:0]     rem_sh;
  logic              div_ge;
  logic [DENW:0]     rem_new;
  logic [MSW-1:0]    ms_sat;
  logic [MSW:0]      trial;
  logic              sq_ge;
  logic [RMSW-1:0]   rms;
  logic              saturated;

  always_comb begin
    rem_sh  = {rem_q, num_q[NUMW-1]};
    div_ge  = (rem_sh >= {1'b0, den_q});
    rem_new = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    ms_sat  = (num_q > NUMW'(pdmrms_pkg::MS_MAX)) ? pdmrms_pkg::MS_MAX : num_q[MSW-1:0];
    trial   = r_q + (MSW+1)'(bit_q);
    sq_ge   = ((MSW+1)'(x_q) >= trial);
    rms     = r_q[RMSW-1:0];
    saturated = (pdmrms_pkg::RMSLIM_W'(rms) > cfg_i.sat_rms_limit) ||
                (PKCW'(peak_q) > PKCW'(cfg_i.sat_peak_limit));
  end

  always_comb begin
    res_o = '0;
    if (saturated) begin
      res_o.status = 1'b1;
    end else begin
      res_o.mean_square = ms_q;
      res_o.rms_level   = rms;
      res_o.peak_level  = (PKCW'(peak_q) > PKCW'(pdmrms_pkg::PEAK_OUT_MAX)) ?
                          pdmrms_pkg::PEAK_OUT_MAX : pdmrms_pkg::PEAK_W'(peak_q);
    end
  end

  assign job_pop_o  = (state_q == ST_IDLE) && job_valid_i;
  assign res_push_o = (state_q == ST_DONE) && !res_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      num_q     <= '0;
      cnt_q     <= '0;
      peak_q    <= '0;
      den_q     <= '0;
      rem_q     <= '0;
      step_q    <= '0;
      ms_q      <= '0;
      x_q       <= '0;
      r_q       <= '0;
      bit_q     <= '0;
      sq_step_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            num_q   <= {job_sum_sq_i, {FW{1'b0}}};
            cnt_q   <= job_count_i;
            peak_q  <= job_peak_i;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          den_q   <= DENW'(cnt_q) * DENW'(TT);
          rem_q   <= '0;
          step_q  <= DIVCW'(NUMW - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= rem_new[DENW-1:0];
          num_q <= {num_q[NUMW-2:0], div_ge};
          if (step_q == '0) begin
            state_q <= ST_SAT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_SAT: begin
          ms_q      <= ms_sat;
          x_q       <= ms_sat;
          r_q       <= '0;
          bit_q     <= pdmrms_pkg::SQRT_BIT0;
          sq_step_q <= SQCW'(pdmrms_pkg::SQRT_STEPS - 1);
          state_q   <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_ge) begin
            x_q <= MSW'((MSW+1)'(x_q) - trial);
            r_q <= (r_q >> 1) + (MSW+1)'(bit_q);
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (sq_step_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            sq_step_q <= sq_step_q - 1'b1;
          end
        end
        ST_DONE: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (den_q != '0))
    else $error("division started with a zero divisor");

  a_sqrt_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> $onehot(bit_q))
    else $error("square root trial bit lost");

  a_rms_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && !res_o.status) |->
      ((32'(res_o.rms_level) * 32'(res_o.rms_level)) <= 32'(res_o.mean_square)))
    else $error("rms level above the root of the mean square");

  a_pop_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (state_q == ST_MUL))
    else $error("job taken without starting the evaluation");

endmodule

`default_nettype wire
